// ----- design/rrx_pkg.sv -----
// Package for the rotate-right-through-extend unit.
// Holds action and size codes, the controller command struct and count helpers.
// No dependencies.
package rrx_pkg;

    localparam int NUM_REGS = 8;
    localparam int REG_AW   = 3;

    localparam logic [1:0] ACT_EXEC      = 2'd0;
    localparam logic [1:0] ACT_LOAD_REG  = 2'd1;
    localparam logic [1:0] ACT_LOAD_FLAG = 2'd2;

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_WORD = 2'd1;
    localparam logic [1:0] SZ_LONG = 2'd2;
    localparam logic [1:0] SZ_MEM  = 2'd3;

    localparam int FLG_X = 4;
    localparam int FLG_N = 3;
    localparam int FLG_Z = 2;
    localparam int FLG_V = 1;
    localparam int FLG_C = 0;

    typedef struct packed {
        logic capture;
        logic amount;
        logic exec;
    } t_ctrl;

    function automatic logic [5:0] f_mod9(input logic [5:0] c);
        logic [5:0] r;
        r = c;
        if (r >= 6'd36) r = r - 6'd36;
        if (r >= 6'd18) r = r - 6'd18;
        if (r >= 6'd9)  r = r - 6'd9;
        return r;
    endfunction

    function automatic logic [5:0] f_mod17(input logic [5:0] c);
        logic [5:0] r;
        r = c;
        if (r >= 6'd34) r = r - 6'd34;
        if (r >= 6'd17) r = r - 6'd17;
        return r;
    endfunction

    function automatic logic [5:0] f_mod33(input logic [5:0] c);
        logic [5:0] r;
        r = c;
        if (r >= 6'd33) r = r - 6'd33;
        return r;
    endfunction

endpackage

// ----- design/rrx_ram.sv -----
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module rrx_ram #(
    parameter int P_WIDTH = 32,
    parameter int P_DEPTH = 8
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]         i_wdata,
    input  logic [$clog2(P_DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(P_DEPTH)-1:0] i_raddr_b,
    output logic [P_WIDTH-1:0]         o_rdata_a,
    output logic [P_WIDTH-1:0]         o_rdata_b
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ----- design/rrx_ctrl.sv -----
// Controller state machine for the rotate-right-through-extend unit.
// Depends on rrx_pkg.
module rrx_ctrl import rrx_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    output logic  o_busy,
    output t_ctrl o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_READ;
            end
            S_READ:  n_state = S_EXEC;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_cmd.capture = (r_state == S_IDLE) && i_start;
    assign o_cmd.amount  = (r_state == S_READ);
    assign o_cmd.exec    = (r_state == S_EXEC);

endmodule

// ----- design/rrx_dpath.sv -----
// Datapath: register file, flags, count reduction and ring rotator.
// Depends on rrx_pkg and rrx_ram.
module rrx_dpath import rrx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctrl       i_cmd,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_opcode,
    input  logic [15:0] i_mem_word,
    input  logic [2:0]  i_reg_index,
    input  logic [31:0] i_load_value,
    output logic        o_valid,
    output logic [31:0] o_result_value,
    output logic        o_to_memory,
    output logic [2:0]  o_dest_reg,
    output logic        o_flag_x,
    output logic        o_flag_n,
    output logic        o_flag_z,
    output logic        o_flag_v,
    output logic        o_flag_c,
    output logic [7:0]  o_cycles
);

    logic [1:0]        r_action;
    logic [15:0]       r_op;
    logic [15:0]       r_mem;
    logic [2:0]        r_ridx;
    logic [31:0]       r_lval;
    logic [NUM_REGS-1:0] r_reg_vld;
    logic              r_vld_a;
    logic              r_vld_b;
    logic [4:0]        r_flags;
    logic [5:0]        r_cnt;
    logic [5:0]        r_amt;
    logic [31:0]       r_old;

    logic [31:0]       w_rd_a;
    logic [31:0]       w_rd_b;
    logic              w_we;
    logic [REG_AW-1:0] w_waddr;
    logic [31:0]       w_wdata;

    logic [1:0]        w_size;
    logic [5:0]        n_cnt;
    logic [5:0]        n_amt;
    logic [31:0]       n_old;

    logic              w_x;
    logic [8:0]        w_ring9;
    logic [16:0]       w_ring17;
    logic [32:0]       w_ring33;
    logic [17:0]       w_dup9;
    logic [33:0]       w_dup17;
    logic [65:0]       w_dup33;
    logic [8:0]        w_rot9;
    logic [16:0]       w_rot17;
    logic [32:0]       w_rot33;

    logic [31:0]       n_result;
    logic              n_to_mem;
    logic [2:0]        n_dreg;
    logic [4:0]        n_flags;
    logic [7:0]        n_cycles;
    logic              w_nx;
    logic              w_nn;
    logic              w_nz;

    rrx_ram #(
        .P_WIDTH (32),
        .P_DEPTH (NUM_REGS)
    ) u_regs (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (i_opcode[11:9]),
        .i_raddr_b (i_opcode[2:0]),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_op     <= i_opcode;
            r_mem    <= i_mem_word;
            r_ridx   <= i_reg_index;
            r_lval   <= i_load_value;
        end
        r_vld_a <= r_reg_vld[i_opcode[11:9]];
        r_vld_b <= r_reg_vld[i_opcode[2:0]];
        if (i_cmd.amount) begin
            r_cnt <= n_cnt;
            r_amt <= n_amt;
            r_old <= n_old;
        end
    end

    assign w_size = r_op[7:6];

    always_comb begin
        logic [31:0] cnt_src;
        cnt_src = r_vld_a ? w_rd_a : 32'd0;
        if (r_op[5]) begin
            n_cnt = cnt_src[5:0];
        end else if (r_op[11:9] == 3'd0) begin
            n_cnt = 6'd8;
        end else begin
            n_cnt = {3'd0, r_op[11:9]};
        end
        n_old = r_vld_b ? w_rd_b : 32'd0;
        case (w_size)
            SZ_BYTE: n_amt = f_mod9(n_cnt);
            SZ_WORD: n_amt = f_mod17(n_cnt);
            SZ_LONG: n_amt = f_mod33(n_cnt);
            default: begin
                n_amt = 6'd1;
                n_old = {16'd0, r_mem};
            end
        endcase
    end

    assign w_x      = r_flags[FLG_X];
    assign w_ring9  = {w_x, r_old[7:0]};
    assign w_ring17 = {w_x, r_old[15:0]};
    assign w_ring33 = {w_x, r_old};
    assign w_dup9   = {w_ring9, w_ring9} >> r_amt;
    assign w_dup17  = {w_ring17, w_ring17} >> r_amt;
    assign w_dup33  = {w_ring33, w_ring33} >> r_amt;
    assign w_rot9   = w_dup9[8:0];
    assign w_rot17  = w_dup17[16:0];
    assign w_rot33  = w_dup33[32:0];

    always_comb begin
        n_result = 32'd0;
        n_to_mem = 1'b0;
        n_dreg   = 3'd0;
        n_flags  = r_flags;
        n_cycles = 8'd0;
        w_we     = 1'b0;
        w_waddr  = r_ridx;
        w_wdata  = r_lval;
        w_nx     = 1'b0;
        w_nn     = 1'b0;
        w_nz     = 1'b0;
        case (r_action)
            ACT_EXEC: begin
                case (w_size)
                    SZ_BYTE: begin
                        w_nx     = w_rot9[8];
                        w_nn     = w_rot9[7];
                        w_nz     = (w_rot9[7:0] == 8'd0);
                        n_result = {r_old[31:8], w_rot9[7:0]};
                    end
                    SZ_WORD: begin
                        w_nx     = w_rot17[16];
                        w_nn     = w_rot17[15];
                        w_nz     = (w_rot17[15:0] == 16'd0);
                        n_result = {r_old[31:16], w_rot17[15:0]};
                    end
                    SZ_LONG: begin
                        w_nx     = w_rot33[32];
                        w_nn     = w_rot33[31];
                        w_nz     = (w_rot33[31:0] == 32'd0);
                        n_result = w_rot33[31:0];
                    end
                    default: begin
                        w_nx     = w_rot17[16];
                        w_nn     = w_rot17[15];
                        w_nz     = (w_rot17[15:0] == 16'd0);
                        n_result = {16'd0, w_rot17[15:0]};
                    end
                endcase
                n_flags = {w_nx, w_nn, w_nz, 1'b0, w_nx};
                if (w_size == SZ_MEM) begin
                    n_to_mem = 1'b1;
                    n_cycles = 8'd8;
                end else begin
                    n_dreg   = r_op[2:0];
                    n_cycles = 8'd6 + {1'b0, r_cnt, 1'b0};
                    if (w_size == SZ_LONG) n_cycles = n_cycles + 8'd2;
                    w_we     = 1'b1;
                    w_waddr  = r_op[2:0];
                    w_wdata  = n_result;
                end
            end
            ACT_LOAD_REG: begin
                n_result = r_lval;
                n_dreg   = r_ridx;
                w_we     = 1'b1;
            end
            ACT_LOAD_FLAG: begin
                n_flags  = r_lval[4:0];
                n_result = {27'd0, r_lval[4:0]};
            end
            default: begin
                n_result = 32'd0;
            end
        endcase
        if (!i_cmd.exec) w_we = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg_vld <= '0;
            r_flags   <= 5'd0;
            o_valid   <= 1'b0;
        end else begin
            o_valid <= i_cmd.exec;
            if (i_cmd.exec) begin
                r_flags <= n_flags;
            end
            if (w_we) begin
                r_reg_vld[w_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            o_result_value <= n_result;
            o_to_memory    <= n_to_mem;
            o_dest_reg     <= n_dreg;
            o_cycles       <= n_cycles;
        end
    end

    assign o_flag_x = r_flags[FLG_X];
    assign o_flag_n = r_flags[FLG_N];
    assign o_flag_z = r_flags[FLG_Z];
    assign o_flag_v = r_flags[FLG_V];
    assign o_flag_c = r_flags[FLG_C];

endmodule

// ----- design/rotate_right_through_extend_unit_core.sv -----
// Top level: rotate right through extend unit with eight data registers and flags.
// Result strobe: registered at the end of the rotate step, after the read and count-reduce steps.
// A new request is accepted only once the read, count-reduce and rotate steps are done (busy low).
// Register file read is registered; the rotate and write happen in the last step.
// Synchronous active-low reset clears registers, flags and controller; the receiver cannot stall.
// Depends on rrx_pkg, rrx_ctrl, rrx_dpath, rrx_ram.
module rotate_right_through_extend_unit_core import rrx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_opcode,
    input  logic [15:0] i_mem_word,
    input  logic [2:0]  i_reg_index,
    input  logic [31:0] i_load_value,
    output logic        o_valid,
    output logic [31:0] o_result_value,
    output logic        o_to_memory,
    output logic [2:0]  o_dest_reg,
    output logic        o_flag_x,
    output logic        o_flag_n,
    output logic        o_flag_z,
    output logic        o_flag_v,
    output logic        o_flag_c,
    output logic [7:0]  o_cycles
);

    t_ctrl w_cmd;

    rrx_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (w_cmd)
    );

    rrx_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_action       (i_action),
        .i_opcode       (i_opcode),
        .i_mem_word     (i_mem_word),
        .i_reg_index    (i_reg_index),
        .i_load_value   (i_load_value),
        .o_valid        (o_valid),
        .o_result_value (o_result_value),
        .o_to_memory    (o_to_memory),
        .o_dest_reg     (o_dest_reg),
        .o_flag_x       (o_flag_x),
        .o_flag_n       (o_flag_n),
        .o_flag_z       (o_flag_z),
        .o_flag_v       (o_flag_v),
        .o_flag_c       (o_flag_c),
        .o_cycles       (o_cycles)
    );

endmodule

// ----- design/rrx_checker.sv -----
// Port-level checker for the rotate right through extend unit, with its bind.
// Depends on rotate_right_through_extend_unit_core.
module rrx_assert (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic       o_to_memory,
    input logic [2:0] o_dest_reg,
    input logic [7:0] o_cycles,
    input logic       o_flag_x,
    input logic       o_flag_c
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted request");

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_valid)
        else $error("result strobe missing three cycles after request");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && $past(busy)))
        else $error("result strobe without a finished request");

    a_mem_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_to_memory) |-> (o_dest_reg == 3'd0 && o_cycles == 8'd8
                                      && o_flag_x == o_flag_c))
        else $error("memory form result fields inconsistent");

endmodule

bind rotate_right_through_extend_unit_core rrx_assert u_rrx_assert (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_to_memory (o_to_memory),
    .o_dest_reg  (o_dest_reg),
    .o_cycles    (o_cycles),
    .o_flag_x    (o_flag_x),
    .o_flag_c    (o_flag_c)
);

// ----- tb/rrx_checker.sv -----
// Checker for the rotate-right-through-extend unit: watches requests and result strobes,
// predicts each result from its own copy of the data registers and flags, and counts mismatches.
// Depends on rrx_pkg.
module rrx_checker import rrx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_opcode,
    input  logic [15:0] i_mem_word,
    input  logic [2:0]  i_reg_index,
    input  logic [31:0] i_load_value,
    input  logic        i_valid,
    input  logic [31:0] i_result_value,
    input  logic        i_to_memory,
    input  logic [2:0]  i_dest_reg,
    input  logic        i_flag_x,
    input  logic        i_flag_n,
    input  logic        i_flag_z,
    input  logic        i_flag_v,
    input  logic        i_flag_c,
    input  logic [7:0]  i_cycles,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results,
    output int          o_reg_rotates,
    output int          o_mem_rotates
);

    typedef struct packed {
        logic [31:0] value;
        logic        to_mem;
        logic [2:0]  dreg;
        logic [4:0]  flags;
        logic [7:0]  cyc;
    } t_outcome;

    logic [31:0] shadow_regs [NUM_REGS];
    logic [4:0]  shadow_flags;
    t_outcome    outcome_q [$];
    t_outcome    want;

    function automatic logic [31:0] rotate_through_x(input logic [31:0] val, input int width,
                                                     input int count, input logic x_in,
                                                     output logic carry);
        logic [31:0] mask;
        logic [31:0] v;
        logic        x;
        logic        out_bit;
        mask  = (width >= 32) ? 32'hffff_ffff : ((32'h1 << width) - 32'h1);
        v     = val & mask;
        x     = x_in;
        carry = x_in;
        for (int k = 0; k < count; k++) begin
            out_bit = v[0];
            v       = (v >> 1) | ({31'b0, x} << (width - 1));
            x       = out_bit;
            carry   = out_bit;
        end
        return v & mask;
    endfunction

    task automatic predict_outcome(input logic [1:0] act, input logic [15:0] op,
                                   input logic [15:0] mem, input logic [2:0] ridx,
                                   input logic [31:0] lval);
        t_outcome    e;
        logic [1:0]  size;
        logic [5:0]  cnt;
        logic [31:0] old;
        logic [31:0] sized;
        logic        carry;
        int          width;
        e = '0;
        case (act)
            ACT_EXEC: begin
                size = op[7:6];
                if (size == SZ_MEM) begin
                    sized = rotate_through_x({16'b0, mem}, 16, 1, shadow_flags[FLG_X], carry);
                    shadow_flags = {carry, sized[15], sized == 32'b0, 1'b0, carry};
                    e.value  = sized;
                    e.to_mem = 1'b1;
                    e.cyc    = 8'd8;
                    o_mem_rotates++;
                end else begin
                    if (op[5]) begin
                        cnt = shadow_regs[op[11:9]][5:0];
                    end else begin
                        cnt = (op[11:9] == 3'd0) ? 6'd8 : {3'b0, op[11:9]};
                    end
                    e.dreg = op[2:0];
                    old    = shadow_regs[op[2:0]];
                    e.cyc  = 8'(6 + 2 * int'(cnt));
                    case (size)
                        SZ_BYTE: width = 8;
                        SZ_WORD: width = 16;
                        default: width = 32;
                    endcase
                    sized = rotate_through_x(old, width, int'(cnt), shadow_flags[FLG_X],
                                             carry);
                    case (size)
                        SZ_BYTE: e.value = {old[31:8], sized[7:0]};
                        SZ_WORD: e.value = {old[31:16], sized[15:0]};
                        default: begin
                            e.value = sized;
                            e.cyc   = e.cyc + 8'd2;
                        end
                    endcase
                    shadow_flags = {carry, sized[width - 1], sized == 32'b0, 1'b0, carry};
                    shadow_regs[op[2:0]] = e.value;
                    o_reg_rotates++;
                end
            end
            ACT_LOAD_REG: begin
                shadow_regs[ridx] = lval;
                e.value = lval;
                e.dreg  = ridx;
            end
            ACT_LOAD_FLAG: begin
                shadow_flags = lval[4:0];
                e.value      = {27'b0, lval[4:0]};
            end
            default: begin
            end
        endcase
        e.flags = shadow_flags;
        outcome_q.push_back(e);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] exp_v,
                                   input logic [31:0] got_v);
        $display("mismatch at %0t: %s expected %h got %h", $time, field, exp_v, got_v);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (shadow_regs[k]) shadow_regs[k] = '0;
            shadow_flags  = '0;
            outcome_q.delete();
            o_fail_count  = 0;
            o_results     = 0;
            o_reg_rotates = 0;
            o_mem_rotates = 0;
        end else begin
            if (i_valid) begin
                o_results++;
                if (outcome_q.size() == 0) begin
                    report_mismatch("unexpected result, value", 32'b0, i_result_value);
                end else begin
                    want = outcome_q.pop_front();
                    if (i_result_value !== want.value)
                        report_mismatch("result_value", want.value, i_result_value);
                    if (i_to_memory !== want.to_mem)
                        report_mismatch("to_memory", 32'(want.to_mem), 32'(i_to_memory));
                    if (i_dest_reg !== want.dreg)
                        report_mismatch("dest_reg", 32'(want.dreg), 32'(i_dest_reg));
                    if (i_flag_x !== want.flags[FLG_X])
                        report_mismatch("flag_x", 32'(want.flags[FLG_X]), 32'(i_flag_x));
                    if (i_flag_n !== want.flags[FLG_N])
                        report_mismatch("flag_n", 32'(want.flags[FLG_N]), 32'(i_flag_n));
                    if (i_flag_z !== want.flags[FLG_Z])
                        report_mismatch("flag_z", 32'(want.flags[FLG_Z]), 32'(i_flag_z));
                    if (i_flag_v !== want.flags[FLG_V])
                        report_mismatch("flag_v", 32'(want.flags[FLG_V]), 32'(i_flag_v));
                    if (i_flag_c !== want.flags[FLG_C])
                        report_mismatch("flag_c", 32'(want.flags[FLG_C]), 32'(i_flag_c));
                    if (i_cycles !== want.cyc)
                        report_mismatch("cycles", 32'(want.cyc), 32'(i_cycles));
                end
            end
            if (i_start && !i_busy)
                predict_outcome(i_action, i_opcode, i_mem_word, i_reg_index, i_load_value);
        end
        o_pending = outcome_q.size();
    end

endmodule

// ----- tb/testbench.sv -----
// Top of the testbench for rotate_right_through_extend_unit_core: clock, reset and request
// stimulus in bursts, a watchdog and the verdict. Depends on rrx_pkg, rrx_checker and the core.
module testbench;
    import rrx_pkg::*;

    localparam int RANDOM_REQUESTS = 1500;
    localparam int WATCHDOG_LIMIT  = 400;
    localparam int DRAIN_CYCLES    = 10;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        start        = 1'b0;
    logic [1:0]  i_action     = '0;
    logic [15:0] i_opcode     = '0;
    logic [15:0] i_mem_word   = '0;
    logic [2:0]  i_reg_index  = '0;
    logic [31:0] i_load_value = '0;
    logic        busy;
    logic        o_valid;
    logic [31:0] o_result_value;
    logic        o_to_memory;
    logic [2:0]  o_dest_reg;
    logic        o_flag_x;
    logic        o_flag_n;
    logic        o_flag_z;
    logic        o_flag_v;
    logic        o_flag_c;
    logic [7:0]  o_cycles;

    int fail_count;
    int pending;
    int result_count;
    int reg_rotates;
    int mem_rotates;
    int request_count;
    int burst_left;
    int quiet_cycles;

    always #5 i_clk = ~i_clk;

    rotate_right_through_extend_unit_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_opcode       (i_opcode),
        .i_mem_word     (i_mem_word),
        .i_reg_index    (i_reg_index),
        .i_load_value   (i_load_value),
        .o_valid        (o_valid),
        .o_result_value (o_result_value),
        .o_to_memory    (o_to_memory),
        .o_dest_reg     (o_dest_reg),
        .o_flag_x       (o_flag_x),
        .o_flag_n       (o_flag_n),
        .o_flag_z       (o_flag_z),
        .o_flag_v       (o_flag_v),
        .o_flag_c       (o_flag_c),
        .o_cycles       (o_cycles)
    );

    rrx_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_action       (i_action),
        .i_opcode       (i_opcode),
        .i_mem_word     (i_mem_word),
        .i_reg_index    (i_reg_index),
        .i_load_value   (i_load_value),
        .i_valid        (o_valid),
        .i_result_value (o_result_value),
        .i_to_memory    (o_to_memory),
        .i_dest_reg     (o_dest_reg),
        .i_flag_x       (o_flag_x),
        .i_flag_n       (o_flag_n),
        .i_flag_z       (o_flag_z),
        .i_flag_v       (o_flag_v),
        .i_flag_c       (o_flag_c),
        .i_cycles       (o_cycles),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results      (result_count),
        .o_reg_rotates  (reg_rotates),
        .o_mem_rotates  (mem_rotates)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    function automatic logic [15:0] rox_opcode(input logic [1:0] size, input logic reg_src,
                                               input logic [2:0] cnt, input logic [2:0] dreg);
        logic [15:0] op;
        op       = 16'($urandom);
        op[11:9] = cnt;
        op[7:6]  = size;
        op[5]    = reg_src;
        op[2:0]  = dreg;
        return op;
    endfunction

    // Hold the request until accepted, then continue the burst or idle for a while.
    task automatic send_request(input logic [1:0] act, input logic [15:0] op,
                                input logic [15:0] mem, input logic [2:0] ridx,
                                input logic [31:0] lval);
        int idle;
        i_action     = act;
        i_opcode     = op;
        i_mem_word   = mem;
        i_reg_index  = ridx;
        i_load_value = lval;
        start        = 1'b1;
        do @(posedge i_clk); while (busy);
        request_count++;
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            idle = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 4);
            if (idle > 0) begin
                start = 1'b0;
                repeat (idle) @(negedge i_clk);
            end
            burst_left = $urandom_range(0, 12);
        end
    endtask

    initial begin
        int          pick;
        logic [31:0] value;
        logic [15:0] mem;
        quiet_cycles  = 0;
        request_count = 0;
        burst_left    = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_request(ACT_LOAD_FLAG, 16'($urandom), 16'($urandom), 3'($urandom), 32'hffff_ffff);
        send_request(ACT_LOAD_REG, 16'($urandom), 16'($urandom), 3'd0, 32'hffff_ffff);
        send_request(ACT_LOAD_REG, 16'($urandom), 16'($urandom), 3'd1, 32'h8000_0001);
        send_request(ACT_LOAD_REG, 16'($urandom), 16'($urandom), 3'd2, 32'h0000_0000);
        send_request(ACT_LOAD_REG, 16'($urandom), 16'($urandom), 3'd3, 32'hffff_ffff);
        send_request(ACT_LOAD_REG, 16'($urandom), 16'($urandom), 3'd4, 32'd33);
        send_request(ACT_LOAD_REG, 16'($urandom), 16'($urandom), 3'd5, 32'd17);
        send_request(ACT_LOAD_REG, 16'($urandom), 16'($urandom), 3'd6, 32'd9);
        send_request(ACT_LOAD_REG, 16'($urandom), 16'($urandom), 3'd7, 32'h1234_5678);
        send_request(ACT_EXEC, rox_opcode(SZ_BYTE, 1'b0, 3'd0, 3'd0), 16'($urandom),
                     3'($urandom), $urandom);
        send_request(ACT_EXEC, rox_opcode(SZ_WORD, 1'b0, 3'd1, 3'd1), 16'($urandom),
                     3'($urandom), $urandom);
        send_request(ACT_EXEC, rox_opcode(SZ_LONG, 1'b0, 3'd7, 3'd7), 16'($urandom),
                     3'($urandom), $urandom);
        send_request(ACT_EXEC, rox_opcode(SZ_LONG, 1'b1, 3'd2, 3'd1), 16'($urandom),
                     3'($urandom), $urandom);
        send_request(ACT_EXEC, rox_opcode(SZ_BYTE, 1'b1, 3'd6, 3'd7), 16'($urandom),
                     3'($urandom), $urandom);
        send_request(ACT_EXEC, rox_opcode(SZ_WORD, 1'b1, 3'd5, 3'd0), 16'($urandom),
                     3'($urandom), $urandom);
        send_request(ACT_EXEC, rox_opcode(SZ_LONG, 1'b1, 3'd4, 3'd1), 16'($urandom),
                     3'($urandom), $urandom);
        send_request(ACT_EXEC, rox_opcode(SZ_LONG, 1'b1, 3'd3, 3'd7), 16'($urandom),
                     3'($urandom), $urandom);
        send_request(ACT_LOAD_FLAG, 16'($urandom), 16'($urandom), 3'($urandom), 32'hffff_ffe0);
        send_request(ACT_EXEC, rox_opcode(SZ_MEM, 1'($urandom), 3'($urandom), 3'($urandom)),
                     16'h0000, 3'($urandom), $urandom);
        send_request(ACT_EXEC, rox_opcode(SZ_MEM, 1'($urandom), 3'($urandom), 3'($urandom)),
                     16'hffff, 3'($urandom), $urandom);
        send_request(ACT_LOAD_FLAG, 16'($urandom), 16'($urandom), 3'($urandom), 32'h0000_0010);
        send_request(ACT_EXEC, rox_opcode(SZ_MEM, 1'($urandom), 3'($urandom), 3'($urandom)),
                     16'h0001, 3'($urandom), $urandom);
        send_request(ACT_EXEC, rox_opcode(SZ_BYTE, 1'b1, 3'd2, 3'd2), 16'($urandom),
                     3'($urandom), $urandom);

        repeat (RANDOM_REQUESTS) begin
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 3))
                0:       mem = 16'($urandom_range(0, 1) ? 16'hffff : 16'h0000);
                1:       mem = 16'(1 << $urandom_range(0, 15));
                default: mem = 16'($urandom);
            endcase
            if (pick < 15) begin
                case ($urandom_range(0, 3))
                    0:       value = $urandom_range(0, 70);
                    1:       value = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
                    2:       value = 32'h1 << $urandom_range(0, 31);
                    default: value = $urandom;
                endcase
                send_request(ACT_LOAD_REG, 16'($urandom), mem, 3'($urandom), value);
            end else if (pick < 22) begin
                send_request(ACT_LOAD_FLAG, 16'($urandom), mem, 3'($urandom), $urandom);
            end else begin
                send_request(ACT_EXEC, 16'($urandom), mem, 3'($urandom), $urandom);
            end
        end

        start = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("requests %0d, results checked %0d", request_count, result_count);
        $display("register rotates %0d, memory rotates %0d, the rest register and flag loads",
                 reg_rotates, mem_rotates);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/rrx_pkg.sv
design/rrx_ram.sv
design/rrx_ctrl.sv
design/rrx_dpath.sv
design/rotate_right_through_extend_unit_core.sv
design/rrx_checker.sv
tb/rrx_checker.sv
tb/testbench.sv
